// ----- hdl/mbe_pkg.sv -----
// Shared types, constants and helper functions for the Mandelbrot escape-time block.
package mbe_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 28;
    localparam int PIXEL_BITS = 12;
    localparam int ITER_BITS  = 16;

    // Multiplier operands carry one extra bit so that unsigned steps and pixels fit.
    localparam int MOP_W  = DATA_WIDTH + 1;
    localparam int PROD_W = 2 * MOP_W;
    // Holds a shifted square or cross product plus a coordinate without overflow.
    localparam int ACC_W  = 2 * DATA_WIDTH - FRAC_BITS + 4;
    localparam int STEP_W = DATA_WIDTH - 1;

    // Register file layout.
    localparam int APB_W      = (DATA_WIDTH > 32) ? 64 : 32;
    localparam int REG_SHIFT  = (DATA_WIDTH > 32) ? 3 : 2;
    localparam int REG_IDX_W  = 3;
    localparam int ADDR_W     = REG_SHIFT + REG_IDX_W;

    localparam logic [REG_IDX_W-1:0] REG_MIN_RE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_IM   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RE_STEP  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IM_STEP  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

    typedef logic signed [DATA_WIDTH-1:0] t_fix;
    typedef logic        [STEP_W-1:0]     t_step;
    typedef logic        [ITER_BITS-1:0]  t_iter;
    typedef logic        [PIXEL_BITS-1:0] t_pix;
    typedef logic signed [MOP_W-1:0]      t_mop;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [ACC_W-1:0]      t_acc;

    typedef struct packed {
        t_pix pixel_x;
        t_pix pixel_y;
    } t_pixel;

    typedef struct packed {
        t_iter escape_count;
        logic  inside_res;
    } t_result;

    typedef struct packed {
        t_fix  min_re;
        t_fix  max_im;
        t_step re_step;
        t_step im_step;
        t_iter max_iterations;
    } t_cfg;

    localparam t_fix  RST_MIN_RE   = -(t_fix'(2) <<< FRAC_BITS);
    localparam t_fix  RST_MAX_IM   = t_fix'(322122547);
    localparam t_step RST_RE_STEP  = t_step'(1260262);
    localparam t_step RST_IM_STEP  = t_step'(1260262);
    localparam t_iter RST_MAX_ITER = t_iter'(100);

    localparam t_fix FIX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_fix FIX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_acc FOUR    = t_acc'(4) <<< FRAC_BITS;

    function automatic t_prod widen_fix(input t_fix v);
        return {{(PROD_W-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
    endfunction

    function automatic t_prod widen_acc(input t_acc v);
        return {{(PROD_W-ACC_W){v[ACC_W-1]}}, v};
    endfunction

    // Clamps a wide signed value to the coordinate range.
    function automatic t_fix sat_prod(input t_prod v);
        t_fix r;
        if ((v[PROD_W-1:DATA_WIDTH-1] == '0) || (v[PROD_W-1:DATA_WIDTH-1] == '1)) begin
            r = v[DATA_WIDTH-1:0];
        end else if (v[PROD_W-1]) begin
            r = FIX_MIN;
        end else begin
            r = FIX_MAX;
        end
        return r;
    endfunction

endpackage

// ----- hdl/mbe_mul.sv -----
// Shared signed multiplier with a registered product.
module mbe_mul (
    input  logic          i_clk,
    input  mbe_pkg::t_mop i_a,
    input  mbe_pkg::t_mop i_b,
    output mbe_pkg::t_prod o_prod
);

    mbe_pkg::t_prod r_prod;
    mbe_pkg::t_prod n_prod;

    assign n_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// ----- hdl/mbe_regs.sv -----
// APB configuration registers for the view window and the iteration limit.
module mbe_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbe_pkg::APB_W-1:0]   pwdata,
    output logic [mbe_pkg::APB_W-1:0]   prdata,
    output logic                        pready,
    output mbe_pkg::t_cfg               o_cfg
);

    mbe_pkg::t_cfg r_cfg;
    mbe_pkg::t_cfg n_cfg;
    logic [mbe_pkg::REG_IDX_W-1:0] idx;
    logic wr_en;

    assign idx    = paddr[mbe_pkg::ADDR_W-1:mbe_pkg::REG_SHIFT];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                mbe_pkg::REG_MIN_RE:   n_cfg.min_re  = pwdata[mbe_pkg::DATA_WIDTH-1:0];
                mbe_pkg::REG_MAX_IM:   n_cfg.max_im  = pwdata[mbe_pkg::DATA_WIDTH-1:0];
                mbe_pkg::REG_RE_STEP:  n_cfg.re_step = pwdata[mbe_pkg::STEP_W-1:0];
                mbe_pkg::REG_IM_STEP:  n_cfg.im_step = pwdata[mbe_pkg::STEP_W-1:0];
                mbe_pkg::REG_MAX_ITER: n_cfg.max_iterations = pwdata[mbe_pkg::ITER_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_re         <= mbe_pkg::RST_MIN_RE;
            r_cfg.max_im         <= mbe_pkg::RST_MAX_IM;
            r_cfg.re_step        <= mbe_pkg::RST_RE_STEP;
            r_cfg.im_step        <= mbe_pkg::RST_IM_STEP;
            r_cfg.max_iterations <= mbe_pkg::RST_MAX_ITER;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (idx)
            mbe_pkg::REG_MIN_RE:   prdata = mbe_pkg::APB_W'(r_cfg.min_re);
            mbe_pkg::REG_MAX_IM:   prdata = mbe_pkg::APB_W'(r_cfg.max_im);
            mbe_pkg::REG_RE_STEP:  prdata = mbe_pkg::APB_W'(r_cfg.re_step);
            mbe_pkg::REG_IM_STEP:  prdata = mbe_pkg::APB_W'(r_cfg.im_step);
            mbe_pkg::REG_MAX_ITER: prdata = mbe_pkg::APB_W'(r_cfg.max_iterations);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/mbe_core.sv -----
// Sequencer that maps a pixel to c and runs z = z^2 + c on the shared multiplier.
module mbe_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mbe_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  mbe_pkg::t_pixel  i_pixel,
    output logic             o_valid,
    input  logic             i_ready,
    output mbe_pkg::t_result o_result
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MRE  = 4'd1;
    localparam logic [3:0] S_MIM  = 4'd2;
    localparam logic [3:0] S_CIM  = 4'd3;
    localparam logic [3:0] S_SQR  = 4'd4;
    localparam logic [3:0] S_SQI  = 4'd5;
    localparam logic [3:0] S_TEST = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]        r_state, n_state;
    mbe_pkg::t_pix     r_px, n_px;
    mbe_pkg::t_pix     r_py, n_py;
    mbe_pkg::t_fix     r_cre, n_cre;
    mbe_pkg::t_fix     r_cim, n_cim;
    mbe_pkg::t_fix     r_zr, n_zr;
    mbe_pkg::t_fix     r_zi, n_zi;
    mbe_pkg::t_acc     r_zr2, n_zr2;
    mbe_pkg::t_acc     r_zi2, n_zi2;
    mbe_pkg::t_iter    r_n, n_n;
    mbe_pkg::t_result  r_res, n_res;
    mbe_pkg::t_result  r_out, n_out;
    logic              r_ovalid, n_ovalid;

    mbe_pkg::t_mop     mul_a, mul_b;
    mbe_pkg::t_prod    prod;
    mbe_pkg::t_prod    sh_sq, sh_x;
    mbe_pkg::t_acc     sq, zrzi;
    mbe_pkg::t_fix     c_im_val;
    logic              out_free;

    mbe_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Arithmetic right shifts round toward minus infinity, as the fixed-point format needs.
    assign sh_sq = prod >>> mbe_pkg::FRAC_BITS;
    assign sh_x  = prod >>> (mbe_pkg::FRAC_BITS - 1);
    assign sq    = sh_sq[mbe_pkg::ACC_W-1:0];
    assign zrzi  = sh_x[mbe_pkg::ACC_W-1:0];
    assign c_im_val = mbe_pkg::sat_prod(mbe_pkg::widen_fix(i_cfg.max_im) - prod);

    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_px     = r_px;
        n_py     = r_py;
        n_cre    = r_cre;
        n_cim    = r_cim;
        n_zr     = r_zr;
        n_zi     = r_zi;
        n_zr2    = r_zr2;
        n_zi2    = r_zi2;
        n_n      = r_n;
        n_res    = r_res;
        n_out    = r_out;
        n_ovalid = r_ovalid && !i_ready;
        mul_a    = '0;
        mul_b    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_px    = i_pixel.pixel_x;
                    n_py    = i_pixel.pixel_y;
                    n_state = S_MRE;
                end
            end
            S_MRE: begin
                mul_a   = {{(mbe_pkg::MOP_W-mbe_pkg::PIXEL_BITS){1'b0}}, r_px};
                mul_b   = {{(mbe_pkg::MOP_W-mbe_pkg::STEP_W){1'b0}}, i_cfg.re_step};
                n_state = S_MIM;
            end
            S_MIM: begin
                n_cre   = mbe_pkg::sat_prod(mbe_pkg::widen_fix(i_cfg.min_re) + prod);
                mul_a   = {{(mbe_pkg::MOP_W-mbe_pkg::PIXEL_BITS){1'b0}}, r_py};
                mul_b   = {{(mbe_pkg::MOP_W-mbe_pkg::STEP_W){1'b0}}, i_cfg.im_step};
                n_state = S_CIM;
            end
            S_CIM: begin
                n_cim = c_im_val;
                n_zr  = r_cre;
                n_zi  = c_im_val;
                n_n   = '0;
                if (i_cfg.max_iterations == '0) begin
                    n_res   = '{escape_count: '0, inside_res: 1'b1};
                    n_state = S_DONE;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                mul_a   = {r_zr[mbe_pkg::DATA_WIDTH-1], r_zr};
                mul_b   = {r_zr[mbe_pkg::DATA_WIDTH-1], r_zr};
                n_state = S_SQI;
            end
            S_SQI: begin
                n_zr2   = sq;
                mul_a   = {r_zi[mbe_pkg::DATA_WIDTH-1], r_zi};
                mul_b   = {r_zi[mbe_pkg::DATA_WIDTH-1], r_zi};
                n_state = S_TEST;
            end
            S_TEST: begin
                n_zi2 = sq;
                if ((r_zr2 + sq) > mbe_pkg::FOUR) begin
                    n_res   = '{escape_count: r_n, inside_res: 1'b0};
                    n_state = S_DONE;
                end else begin
                    mul_a   = {r_zr[mbe_pkg::DATA_WIDTH-1], r_zr};
                    mul_b   = {r_zi[mbe_pkg::DATA_WIDTH-1], r_zi};
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_zi = mbe_pkg::sat_prod(mbe_pkg::widen_acc(zrzi)
                                         + mbe_pkg::widen_fix(r_cim));
                n_zr = mbe_pkg::sat_prod(mbe_pkg::widen_acc(r_zr2 - r_zi2)
                                         + mbe_pkg::widen_fix(r_cre));
                if ((r_n + mbe_pkg::t_iter'(1)) == i_cfg.max_iterations) begin
                    n_res   = '{escape_count: '0, inside_res: 1'b1};
                    n_state = S_DONE;
                end else begin
                    n_n     = r_n + mbe_pkg::t_iter'(1);
                    n_state = S_SQR;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px  <= n_px;
        r_py  <= n_py;
        r_cre <= n_cre;
        r_cim <= n_cim;
        r_zr  <= n_zr;
        r_zi  <= n_zi;
        r_zr2 <= n_zr2;
        r_zi2 <= n_zi2;
        r_n   <= n_n;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_out;

endmodule

// ----- hdl/mandelbrot_escape_time.sv -----
// Top level of the Mandelbrot escape-time evaluator.
// Each accepted pixel beat is mapped to c = (min_re + x*re_step, max_im - y*im_step) in
// signed Q4.28, saturated, and iterated as z = z^2 + c from z = c until |z|^2 exceeds four
// or max_iterations steps pass. A pixel offered to the idle block is mapped to c in the
// states MRE, MIM and CIM; each completed iteration runs SQR, SQI, TEST and UPD, and a pixel
// that escapes runs SQR, SQI and TEST once more for its final magnitude test. In DONE the
// result waits for a free output register. The next pixel is accepted in the cycle its
// result first appears. The length of an iteration is set by the single shared
// 33x33 multiplier, which forms z_re^2, z_im^2 and z_re*z_im in turn for every completed iteration.
// The block takes one pixel at a time; a finished result waits in the output register while
// the next pixel is already accepted. Registers sit on an APB port at byte offsets 0x00
// min_re, 0x04 max_im, 0x08 re_step, 0x0C im_step, 0x10 max_iterations, and should be
// written only while no pixel is in flight.
module mandelbrot_escape_time (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbe_pkg::APB_W-1:0]   pwdata,
    output logic [mbe_pkg::APB_W-1:0]   prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  mbe_pkg::t_pixel             i_pixel,
    output logic                        o_valid,
    input  logic                        i_ready,
    output mbe_pkg::t_result            o_result
);

    mbe_pkg::t_cfg cfg;

    mbe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mbe_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_pixel  (i_pixel),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

endmodule

// ----- tb/mandelbrot_escape_time_tb.sv -----
// Self-checking testbench for the Mandelbrot escape-time block.
module mandelbrot_escape_time_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE            = 1 << mbe_pkg::FRAC_BITS;
    localparam int HOLD_CYCLES    = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int SEGMENT_ITEMS  = 150;

    // Tracks the register values and the escape results still owed by the block.
    class escape_scoreboard;
        longint            min_re;
        longint            max_im;
        longint            re_step;
        longint            im_step;
        int unsigned       max_iterations;
        mbe_pkg::t_result  expected_escapes[$];
        int unsigned       mismatches;

        function new();
            min_re         = longint'(mbe_pkg::RST_MIN_RE);
            max_im         = longint'(mbe_pkg::RST_MAX_IM);
            re_step        = longint'(mbe_pkg::RST_RE_STEP);
            im_step        = longint'(mbe_pkg::RST_IM_STEP);
            max_iterations = 32'(mbe_pkg::RST_MAX_ITER);
            mismatches     = 0;
        endfunction

        function void set_register(logic [mbe_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                mbe_pkg::REG_MIN_RE:   min_re = longint'($signed(value));
                mbe_pkg::REG_MAX_IM:   max_im = longint'($signed(value));
                mbe_pkg::REG_RE_STEP:  re_step = longint'(value[mbe_pkg::STEP_W-1:0]);
                mbe_pkg::REG_IM_STEP:  im_step = longint'(value[mbe_pkg::STEP_W-1:0]);
                mbe_pkg::REG_MAX_ITER: max_iterations = 32'(value[mbe_pkg::ITER_BITS-1:0]);
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(logic [mbe_pkg::REG_IDX_W-1:0] idx);
            logic [31:0] v;
            v = '0;
            case (idx)
                mbe_pkg::REG_MIN_RE:   v = min_re[31:0];
                mbe_pkg::REG_MAX_IM:   v = max_im[31:0];
                mbe_pkg::REG_RE_STEP:  v = re_step[31:0];
                mbe_pkg::REG_IM_STEP:  v = im_step[31:0];
                mbe_pkg::REG_MAX_ITER: v = 32'(max_iterations);
                default: ;
            endcase
            return v;
        endfunction

        function longint clamp(longint v);
            longint hi;
            longint lo;
            hi = longint'(mbe_pkg::FIX_MAX);
            lo = longint'(mbe_pkg::FIX_MIN);
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function mbe_pkg::t_result escape_of(mbe_pkg::t_pixel p);
            longint            c_re;
            longint            c_im;
            longint            zr;
            longint            zi;
            longint            zr2;
            longint            zi2;
            longint            zrzi;
            longint            four;
            int unsigned       n;
            mbe_pkg::t_result  r;
            c_re = clamp(min_re + longint'(p.pixel_x) * re_step);
            c_im = clamp(max_im - longint'(p.pixel_y) * im_step);
            zr   = c_re;
            zi   = c_im;
            four = longint'(4) <<< mbe_pkg::FRAC_BITS;
            r.escape_count = '0;
            r.inside_res   = 1'b1;
            for (n = 0; n < max_iterations; n++) begin
                // Arithmetic shifts of signed products round toward minus infinity.
                zr2 = (zr * zr) >>> mbe_pkg::FRAC_BITS;
                zi2 = (zi * zi) >>> mbe_pkg::FRAC_BITS;
                if (zr2 + zi2 > four) begin
                    r.escape_count = mbe_pkg::t_iter'(n);
                    r.inside_res   = 1'b0;
                    break;
                end
                zrzi = (zr * zi) >>> (mbe_pkg::FRAC_BITS - 1);
                zi = clamp(zrzi + c_im);
                zr = clamp(zr2 - zi2 + c_re);
            end
            return r;
        endfunction

        function void report(string text);
            mismatches++;
            if (mismatches <= 10) $display("%s", text);
        endfunction

        function void note_pixel(mbe_pkg::t_pixel p);
            expected_escapes.push_back(escape_of(p));
        endfunction

        function void check_result(mbe_pkg::t_result got);
            mbe_pkg::t_result want;
            if (expected_escapes.size() == 0) begin
                report($sformatf("result beat with nothing expected: count %0d inside %0b",
                                 got.escape_count, got.inside_res));
                return;
            end
            want = expected_escapes.pop_front();
            if (got.escape_count !== want.escape_count)
                report($sformatf("escape_count: expected %0d, got %0d",
                                 want.escape_count, got.escape_count));
            if (got.inside_res !== want.inside_res)
                report($sformatf("inside_res: expected %0b, got %0b",
                                 want.inside_res, got.inside_res));
        endfunction

        function int pending();
            return expected_escapes.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [mbe_pkg::ADDR_W-1:0]   paddr;
    logic [mbe_pkg::APB_W-1:0]    pwdata;
    logic [mbe_pkg::APB_W-1:0]    prdata;
    logic                         pready;
    logic                         i_valid;
    logic                         o_ready;
    mbe_pkg::t_pixel              i_pixel;
    logic                         o_valid;
    logic                         i_ready;
    mbe_pkg::t_result             o_result;

    escape_scoreboard    sb;
    int unsigned         send_idle_pct;
    int unsigned         recv_stall_pct;
    bit                  hold_request;
    int unsigned         hold_left;
    int unsigned         quiet_cycles;

    mandelbrot_escape_time i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_pixel  (i_pixel),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold-off while the sender keeps offering pixels.
    initial begin
        i_ready   <= 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_result);
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || psel) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("mandelbrot_escape_time: mismatch");
        $finish;
    end

    function automatic mbe_pkg::t_pixel pix(int x, int y);
        mbe_pkg::t_pixel p;
        p.pixel_x = mbe_pkg::t_pix'(x);
        p.pixel_y = mbe_pkg::t_pix'(y);
        return p;
    endfunction

    // All driving tasks start and end at a falling edge.
    task automatic send_pixel(input mbe_pkg::t_pixel p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= p;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(p);
        @(negedge i_clk);
    endtask

    task automatic check_reg(input logic [mbe_pkg::REG_IDX_W-1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= mbe_pkg::ADDR_W'(idx) << mbe_pkg::REG_SHIFT;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[31:0] !== sb.register_value(idx))
            sb.report($sformatf("register %0d readback: expected %h, got %h",
                                idx, sb.register_value(idx), prdata[31:0]));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mbe_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mbe_pkg::ADDR_W'(idx) << mbe_pkg::REG_SHIFT;
        pwdata  <= mbe_pkg::APB_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
        @(negedge i_clk);
        check_reg(idx);
    endtask

    task automatic configure(input logic [31:0] re0, input logic [31:0] im0,
                             input logic [31:0] re_inc, input logic [31:0] im_inc,
                             input logic [31:0] iter_limit);
        write_reg(mbe_pkg::REG_MIN_RE, re0);
        write_reg(mbe_pkg::REG_MAX_IM, im0);
        write_reg(mbe_pkg::REG_RE_STEP, re_inc);
        write_reg(mbe_pkg::REG_IM_STEP, im_inc);
        write_reg(mbe_pkg::REG_MAX_ITER, iter_limit);
    endtask

    // Waits until every pixel has come back, so the block is idle for register writes.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [mbe_pkg::REG_IDX_W-1:0] idx;
        int unsigned          kind;
        int unsigned          phase;
        int unsigned          seg;
        int unsigned          k;
        int unsigned          idle_of[4];
        int unsigned          stall_of[4];
        logic [31:0]          r_min;
        logic [31:0]          r_max;
        logic [31:0]          r_rs;
        logic [31:0]          r_is;
        logic [31:0]          r_it;

        idle_of  = '{0, 82, 0, 23};
        stall_of = '{0, 0, 82, 23};
        sb = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_pixel <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (idx = mbe_pkg::REG_MIN_RE; idx <= mbe_pkg::REG_MAX_ITER; idx++) check_reg(idx);

        // Reset view: image corners, a point inside the set and alternating bit patterns.
        send_pixel(pix(0, 0));
        send_pixel(pix(4095, 4095));
        send_pixel(pix(4095, 0));
        send_pixel(pix(0, 4095));
        send_pixel(pix(426, 256));
        send_pixel(pix(2730, 1365));
        send_pixel(pix(1365, 2730));
        drain();

        // With zero steps every pixel maps onto (min_re, max_im).
        // At -2 the orbit sits on |z|^2 == 4 and never escapes, even at the largest limit.
        configure(32'(-2 * ONE), 32'd0, 32'd0, 32'd0, 32'd65535);
        send_pixel(pix(17, 99));
        drain();
        // At +2 the first test sees exactly four, so the escape comes one step later.
        write_reg(mbe_pkg::REG_MIN_RE, 32'(2 * ONE));
        send_pixel(pix(4095, 4095));
        drain();
        write_reg(mbe_pkg::REG_MIN_RE, mbe_pkg::FIX_MIN);
        send_pixel(pix(0, 0));
        drain();

        // A zero iteration limit reports inside without iterating.
        write_reg(mbe_pkg::REG_MAX_ITER, 32'd0);
        send_pixel(pix(1, 1));
        drain();
        configure(32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
        send_pixel(pix(5, 7));
        drain();

        // Coordinates beyond the Q4.28 range saturate.
        configure(mbe_pkg::FIX_MAX, mbe_pkg::FIX_MIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd4);
        send_pixel(pix(4095, 4095));
        send_pixel(pix(0, 0));
        send_pixel(pix(1, 1));
        drain();
        configure(mbe_pkg::FIX_MIN, mbe_pkg::FIX_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd4);
        send_pixel(pix(4095, 4095));
        send_pixel(pix(0, 0));
        send_pixel(pix(2048, 2048));
        drain();

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_of[phase];
            recv_stall_pct = stall_of[phase];
            for (seg = 0; seg < 3; seg++) begin
                kind = $urandom_range(9);
                r_it = 32'($urandom_range(64, 1));
                if (kind == 0) begin
                    r_min = $urandom;
                    r_max = $urandom;
                    r_rs  = $urandom;
                    r_is  = $urandom;
                end else if (kind == 1) begin
                    // Deep zoom near the boundary, where orbits run long.
                    r_min = 32'(-201326592 + int'($urandom_range(2000000)));
                    r_max = 32'(26843545 + int'($urandom_range(2000000)));
                    r_rs  = 32'($urandom_range(300));
                    r_is  = 32'($urandom_range(300));
                end else begin
                    r_min = 32'(-671088640 + int'($urandom_range(939524096)));
                    r_max = 32'(-134217728 + int'($urandom_range(671088640)));
                    r_rs  = 32'($urandom_range(200000, 20000));
                    r_is  = 32'($urandom_range(200000, 20000));
                end
                configure(r_min, r_max, r_rs, r_is, r_it);
                if (phase == 0 && seg == 1) hold_request = 1'b1;
                for (k = 0; k < SEGMENT_ITEMS; k++)
                    send_pixel(pix(int'($urandom_range(4095)), int'($urandom_range(4095))));
                drain();
            end
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("mandelbrot_escape_time: match");
        end else begin
            $display("mandelbrot_escape_time: mismatch");
        end
        $finish;
    end
endmodule
